// ----- hdl/segi_pkg.sv -----
package segi_pkg;

  localparam int unsigned CoordWidth = 16;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_start_x;
    logic signed [CoordWidth-1:0] a_start_y;
    logic signed [CoordWidth-1:0] a_end_x;
    logic signed [CoordWidth-1:0] a_end_y;
    logic signed [CoordWidth-1:0] b_start_x;
    logic signed [CoordWidth-1:0] b_start_y;
    logic signed [CoordWidth-1:0] b_end_x;
    logic signed [CoordWidth-1:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] cross_x;
    logic signed [CoordWidth-1:0] cross_y;
  } seg_out_t;

endpackage

// ----- hdl/segment_intersection_unit.sv -----
// Segment intersection unit. Takes one pair of 2D segments per cycle and
// returns a hit flag and the meeting point, truncated toward zero along B.
// The pipeline is four front stages, CoordWidth + 1 divider stages and
// the output register. The depth comes from a restoring divider unrolled one
// quotient bit per pipeline stage, which also lets a new pair enter every
// cycle while the output is not stalled. A stall at the output freezes the
// whole pipe.
module segment_intersection_unit
  import segi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  seg_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output seg_out_t out_data_o
);

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned QW = W + 1;
  localparam int unsigned NW = PW + DW;
  localparam int unsigned NS = QW;

  logic adv;
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: differences
  logic v1_q;
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, wx_q, wy_q;
  logic signed [W-1:0]  bx0_q, by0_q;

  // stage 2: products
  logic v2_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DW-1:0] dbx2_q, dby2_q;
  logic signed [W-1:0]  bx2_q, by2_q;

  // stage 3: cross products, sign fixup, range test
  logic v3_q, ok3_q;
  logic [PW-1:0] den3_q, tn3_q;
  logic [W-1:0]  mx3_q, my3_q;
  logic          sx3_q, sy3_q;
  logic signed [W-1:0] bx3_q, by3_q;

  // stage 4 (divider entry, index 0): numerators tn*|d|
  // divider: one quotient bit per stage, quotient < 2^QW
  logic [NS:0]   dv_q;
  logic [NS:0]   dok_q;
  logic [NW-1:0] rx_q [NS+1];
  logic [NW-1:0] ry_q [NS+1];
  logic [QW-1:0] qx_q [NS+1];
  logic [QW-1:0] qy_q [NS+1];
  logic [PW-1:0] dd_q [NS+1];
  logic [NS:0]   dsx_q, dsy_q;
  logic signed [W-1:0] dbx_q2 [NS+1];
  logic signed [W-1:0] dby_q2 [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      dv_q[0] <= v3_q;
    end
  end

  logic signed [PW-1:0] den_c, tn_c, un_c, dena, tna, una;
  always_comb begin
    den_c = p0_q - p1_q;
    tn_c  = p2_q - p3_q;
    un_c  = p4_q - p5_q;
    dena  = den_c[PW-1] ? -den_c : den_c;
    tna   = den_c[PW-1] ? -tn_c : tn_c;
    una   = den_c[PW-1] ? -un_c : un_c;
  end

  logic [DW-1:0] adbx, adby;
  assign adbx = dbx2_q[DW-1] ? DW'(-dbx2_q) : DW'(dbx2_q);
  assign adby = dby2_q[DW-1] ? DW'(-dby2_q) : DW'(dby2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dax_q <= DW'(in_data_i.a_end_x) - DW'(in_data_i.a_start_x);
      day_q <= DW'(in_data_i.a_end_y) - DW'(in_data_i.a_start_y);
      dbx_q <= DW'(in_data_i.b_end_x) - DW'(in_data_i.b_start_x);
      dby_q <= DW'(in_data_i.b_end_y) - DW'(in_data_i.b_start_y);
      wx_q  <= DW'(in_data_i.a_start_x) - DW'(in_data_i.b_start_x);
      wy_q  <= DW'(in_data_i.a_start_y) - DW'(in_data_i.b_start_y);
      bx0_q <= in_data_i.b_start_x;
      by0_q <= in_data_i.b_start_y;

      p0_q <= PW'(dax_q) * PW'(dby_q);
      p1_q <= PW'(day_q) * PW'(dbx_q);
      p2_q <= PW'(dax_q) * PW'(wy_q);
      p3_q <= PW'(day_q) * PW'(wx_q);
      p4_q <= PW'(dbx_q) * PW'(wy_q);
      p5_q <= PW'(dby_q) * PW'(wx_q);
      dbx2_q <= dbx_q;
      dby2_q <= dby_q;
      bx2_q  <= bx0_q;
      by2_q  <= by0_q;

      ok3_q  <= (den_c != '0) && !tna[PW-1] && (tna <= dena)
                && !una[PW-1] && (una <= dena);
      den3_q <= dena;
      tn3_q  <= tna;
      mx3_q  <= adbx[W-1:0];
      my3_q  <= adby[W-1:0];
      sx3_q  <= dbx2_q[DW-1];
      sy3_q  <= dby2_q[DW-1];
      bx3_q  <= bx2_q;
      by3_q  <= by2_q;

      dok_q[0]  <= ok3_q;
      rx_q[0]   <= NW'(tn3_q) * NW'(mx3_q);
      ry_q[0]   <= NW'(tn3_q) * NW'(my3_q);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      dd_q[0]   <= den3_q;
      dsx_q[0]  <= sx3_q;
      dsy_q[0]  <= sy3_q;
      dbx_q2[0] <= bx3_q;
      dby_q2[0] <= by3_q;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int unsigned Sh = QW - 1 - s;
    logic [NW+QW-1:0] dsh;
    logic             gx, gy;
    assign dsh = (NW+QW)'(dd_q[s]) << Sh;
    assign gx  = (NW+QW)'(rx_q[s]) >= dsh;
    assign gy  = (NW+QW)'(ry_q[s]) >= dsh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (adv) begin
        dv_q[s+1] <= dv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dok_q[s+1]  <= dok_q[s];
        rx_q[s+1]   <= gx ? rx_q[s] - NW'(dsh) : rx_q[s];
        ry_q[s+1]   <= gy ? ry_q[s] - NW'(dsh) : ry_q[s];
        qx_q[s+1]   <= qx_q[s] | (QW'(gx) << Sh);
        qy_q[s+1]   <= qy_q[s] | (QW'(gy) << Sh);
        dd_q[s+1]   <= dd_q[s];
        dsx_q[s+1]  <= dsx_q[s];
        dsy_q[s+1]  <= dsy_q[s];
        dbx_q2[s+1] <= dbx_q2[s];
        dby_q2[s+1] <= dby_q2[s];
      end
    end
  end

  // output register
  logic     ov_q;
  seg_out_t od_q;
  logic [W-1:0] fx, fy;
  assign fx = dsx_q[NS] ? W'(dbx_q2[NS]) - W'(qx_q[NS]) : W'(dbx_q2[NS]) + W'(qx_q[NS]);
  assign fy = dsy_q[NS] ? W'(dby_q2[NS]) - W'(qy_q[NS]) : W'(dby_q2[NS]) + W'(qy_q[NS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= dv_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q.hit     <= dok_q[NS];
      od_q.cross_x <= dok_q[NS] ? fx : '0;
      od_q.cross_y <= dok_q[NS] ? fy : '0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.cross_x == '0 && out_data_o.cross_y == '0)
    else $error("miss with nonzero point");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] && dok_q[0] |-> dd_q[0] != '0)
    else $error("hit with zero denominator");
`endif

endmodule
